// ===== rtl/core/dte_pkg.sv =====
// shared types and constants for the edge table
`default_nettype none

package dte_pkg;

  localparam int unsigned IdW          = 10;
  localparam int unsigned NumPointsDef = 1024;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP_SMALL = 2'd1,
    REQ_POP_POINT = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NONE     = 2'd1,
    STAT_OVERFILL = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    RD_A    = 2'd0,
    RD_B    = 2'd1,
    RD_P    = 2'd2,
    RD_SCAN = 2'd3
  } rd_sel_e;

  // slot 0 valid lives in the occupancy rows
  typedef struct packed {
    logic           v1;
    logic [IdW-1:0] s0;
    logic [IdW-1:0] e0;
    logic [IdW-1:0] s1;
    logic [IdW-1:0] e1;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   occ;
    logic   is_new;
    logic   found;
  } upd_t;

  typedef struct packed {
    logic    ld_req;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    cap_p;
    logic    scan_chk;
    logic    wr_a;
    logic    wr_b;
    logic    clr_wr;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic cnt_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dte_intf.sv =====
// request and response channel interfaces
`default_nettype none

interface dte_req_if;
  import dte_pkg::*;
  logic           valid;
  logic           ready;
  logic [1:0]     req_type;
  logic [IdW-1:0] edge_start;
  logic [IdW-1:0] edge_end;
  logic [IdW-1:0] query_point;

  modport source (output valid, req_type, edge_start, edge_end, query_point, input ready);
  modport sink   (input valid, req_type, edge_start, edge_end, query_point, output ready);
endinterface

interface dte_rsp_if;
  import dte_pkg::*;
  logic           valid;
  logic           ready;
  logic [1:0]     status;
  logic [1:0]     edge_count;
  logic [IdW-1:0] first_start;
  logic [IdW-1:0] first_end;
  logic [IdW-1:0] second_start;
  logic [IdW-1:0] second_end;
  logic           start_is_new;
  logic           end_is_new;

  modport source (output valid, status, edge_count, first_start, first_end, second_start,
                  second_end, start_is_new, end_is_new, input ready);
  modport sink   (input valid, status, edge_count, first_start, first_end, second_start,
                  second_end, start_is_new, end_is_new, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dte_ctrl.sv =====
// sequencer for table operations
`default_nettype none

module dte_ctrl
  import dte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_RD_P     = 4'd4;
  localparam logic [3:0] S_CAP_P    = 4'd5;
  localparam logic [3:0] S_RD_A     = 4'd6;
  localparam logic [3:0] S_RD_B     = 4'd7;
  localparam logic [3:0] S_CAP_B    = 4'd8;
  localparam logic [3:0] S_WR_A     = 4'd9;
  localparam logic [3:0] S_WR_B     = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       pop_point_q, pop_point_d;

  always_comb begin
    state_d     = state_q;
    pop_point_d = pop_point_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_A;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_req  = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          pop_point_d   = (req_type_i == REQ_POP_POINT);
          state_d       = (req_type_i == REQ_POP_SMALL) ? S_SCAN_RD : S_RD_A;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SCAN;
        state_d      = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.scan_hit)      state_d = S_RD_P;
        else if (sts_i.cnt_last) state_d = S_FIN;
        else                     state_d = S_SCAN_RD;
      end
      S_RD_P: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_P;
        state_d      = S_CAP_P;
      end
      S_CAP_P: begin
        cmd_o.cap_p = 1'b1;
        state_d     = S_RD_A;
      end
      S_RD_A: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_A;
        state_d      = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_B;
        state_d      = S_CAP_B;
      end
      S_CAP_B: begin
        cmd_o.cap_b = 1'b1;
        state_d     = S_WR_A;
      end
      S_WR_A: begin
        cmd_o.wr_a = 1'b1;
        state_d    = pop_point_q ? S_FIN : S_WR_B;
      end
      S_WR_B: begin
        cmd_o.wr_b = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      pop_point_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pop_point_q <= pop_point_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dte_datapath.sv =====
// entry memory, occupancy rows, edge compare and result register
`default_nettype none

module dte_datapath
  import dte_pkg::*;
#(
  parameter int unsigned NUM_POINTS = NumPointsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     req_type_i,
  input  logic [IdW-1:0] edge_start_i,
  input  logic [IdW-1:0] edge_end_i,
  input  logic [IdW-1:0] query_point_i,
  input  cmd_t           cmd_i,
  output sts_t           sts_o,
  output logic [1:0]     status_o,
  output logic [1:0]     edge_count_o,
  output logic [IdW-1:0] first_start_o,
  output logic [IdW-1:0] first_end_o,
  output logic [IdW-1:0] second_start_o,
  output logic [IdW-1:0] second_end_o,
  output logic           start_is_new_o,
  output logic           end_is_new_o
);

  localparam int unsigned AW   = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned OccW = (NUM_POINTS >= 32) ? 32 : 4;
  localparam int unsigned ObW  = $clog2(OccW);
  localparam int unsigned Rows = (NUM_POINTS + OccW - 1) / OccW;
  localparam int unsigned RW   = (Rows > 1) ? $clog2(Rows) : 1;

  function automatic logic [AW-1:0] to_addr(input logic [IdW-1:0] id);
    logic [IdW+AW-1:0] w;
    w = {{AW{1'b0}}, id};
    return w[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [IdW-1:0] id);
    logic [IdW+AW:0] w;
    w = {{(AW+1){1'b0}}, id};
    return w < (IdW+AW+1)'(NUM_POINTS);
  endfunction

  function automatic logic [RW-1:0] row_of(input logic [AW-1:0] a);
    logic [AW+RW-1:0] w;
    w = {{RW{1'b0}}, a} >> ObW;
    return w[RW-1:0];
  endfunction

  function automatic upd_t update(input entry_t ent, input logic occ, input logic m0,
                                  input logic m1, input logic [1:0] req, input logic ovf,
                                  input logic [IdW-1:0] s, input logic [IdW-1:0] e);
    upd_t u;
    u.ent    = ent;
    u.occ    = occ;
    u.is_new = 1'b0;
    u.found  = 1'b0;
    case (req)
      REQ_INSERT: begin
        if (!ovf) begin
          if (!occ) begin
            u.ent.v1 = 1'b0;
            u.ent.s0 = s;
            u.ent.e0 = e;
            u.occ    = 1'b1;
            u.is_new = 1'b1;
          end else if (!(m0 || m1)) begin
            u.ent.v1 = 1'b1;
            u.ent.s1 = s;
            u.ent.e1 = e;
          end
        end
      end
      REQ_POP_POINT: u.occ = 1'b0;
      default: begin
        if (m0) begin
          u.ent.s0 = ent.s1;
          u.ent.e0 = ent.e1;
          u.ent.v1 = 1'b0;
          u.occ    = ent.v1;
          u.found  = 1'b1;
        end else if (m1) begin
          u.ent.v1 = 1'b0;
          u.found  = 1'b1;
        end
      end
    endcase
    return u;
  endfunction

  entry_t          ent_mem [NUM_POINTS];
  logic [OccW-1:0] occ_mem [Rows];

  logic [1:0]      req_q;
  logic [IdW-1:0]  s_q, e_q, q_q;
  logic [AW-1:0]   p_q;
  logic            empty_q;
  logic [RW-1:0]   cnt_q;
  entry_t          rd_ent_q, ent_a_q, ent_b_q;
  logic [OccW-1:0] rd_occ_q, occrow_a_q, occrow_b_q;

  logic [1:0]      status_q, count_q;
  logic [IdW-1:0]  fs_q, fe_q, ss_q, se_q;
  logic            snew_q, enew_q;

  logic [IdW-1:0]  id_a;
  logic [AW-1:0]   addr_a, addr_b, rd_addr;
  logic [RW-1:0]   row_a, row_b, rd_row;
  logic [ObW-1:0]  bit_a, bit_b, idx;
  logic            in_a, in_b, occ_a, occ_b;
  logic            m0_a, m1_a, m0_b, m1_b, ovf;
  upd_t            upd_a, upd_b;
  logic [OccW-1:0] wrow_a, wrow_b;
  logic            hit;
  logic [RW+ObW+AW-1:0] pw;

  assign id_a   = (req_q == REQ_POP_POINT) ? q_q : s_q;
  assign addr_a = to_addr(id_a);
  assign addr_b = to_addr(e_q);
  assign row_a  = row_of(addr_a);
  assign row_b  = row_of(addr_b);
  assign bit_a  = addr_a[ObW-1:0];
  assign bit_b  = addr_b[ObW-1:0];
  assign in_a   = in_range(id_a);
  // a self loop is handled once, at the start point
  assign in_b   = in_range(e_q) && (e_q != s_q) && (req_q != REQ_POP_POINT);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_B:    rd_addr = addr_b;
      RD_P:    rd_addr = p_q;
      default: rd_addr = addr_a;
    endcase
    rd_row = (cmd_i.rd_sel == RD_SCAN) ? cnt_q : row_of(rd_addr);
  end

  assign occ_a = occrow_a_q[bit_a];
  assign occ_b = occrow_b_q[bit_b];
  assign m0_a  = occ_a && ent_a_q.s0 == s_q && ent_a_q.e0 == e_q;
  assign m1_a  = occ_a && ent_a_q.v1 && ent_a_q.s1 == s_q && ent_a_q.e1 == e_q;
  assign m0_b  = occ_b && ent_b_q.s0 == s_q && ent_b_q.e0 == e_q;
  assign m1_b  = occ_b && ent_b_q.v1 && ent_b_q.s1 == s_q && ent_b_q.e1 == e_q;
  assign ovf   = (in_a && occ_a && !(m0_a || m1_a) && ent_a_q.v1) ||
                 (in_b && occ_b && !(m0_b || m1_b) && ent_b_q.v1);

  assign upd_a = update(ent_a_q, occ_a, m0_a, m1_a, req_q, ovf, s_q, e_q);
  assign upd_b = update(ent_b_q, occ_b, m0_b, m1_b, req_q, ovf, s_q, e_q);

  // row b was read before row a was written, so fold a's bit in when they share a row
  always_comb begin
    wrow_a        = occrow_a_q;
    wrow_a[bit_a] = upd_a.occ;
    wrow_b        = occrow_b_q;
    if (in_a && row_a == row_b) wrow_b[bit_a] = upd_a.occ;
    wrow_b[bit_b] = upd_b.occ;
  end

  // lowest occupied point in the scanned row
  always_comb begin
    idx = '0;
    for (int i = OccW - 1; i >= 0; i--) begin
      if (rd_occ_q[i]) idx = ObW'(i);
    end
  end
  assign hit = |rd_occ_q;
  assign pw  = {{AW{1'b0}}, cnt_q, idx};

  assign sts_o.scan_hit = hit;
  assign sts_o.cnt_last = (cnt_q == RW'(Rows - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && in_a)      ent_mem[addr_a] <= upd_a.ent;
    else if (cmd_i.wr_b && in_b) ent_mem[addr_b] <= upd_b.ent;
    if (cmd_i.rd_en)             rd_ent_q <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr)            occ_mem[cnt_q] <= '0;
    else if (cmd_i.wr_a && in_a) occ_mem[row_a] <= wrow_a;
    else if (cmd_i.wr_b && in_b) occ_mem[row_b] <= wrow_b;
    if (cmd_i.rd_en)             rd_occ_q <= occ_mem[rd_row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q <= req_type_i;
      s_q   <= edge_start_i;
      e_q   <= edge_end_i;
      q_q   <= query_point_i;
    end
    if (cmd_i.scan_chk) begin
      empty_q <= !hit;
      p_q     <= pw[AW-1:0];
    end
    if (cmd_i.cap_p) begin
      s_q <= rd_ent_q.s0;
      e_q <= rd_ent_q.e0;
    end
    if (cmd_i.cap_a) begin
      ent_a_q    <= rd_ent_q;
      occrow_a_q <= rd_occ_q;
    end
    if (cmd_i.cap_b) begin
      ent_b_q    <= rd_ent_q;
      occrow_b_q <= rd_occ_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= STAT_OK;
      count_q  <= 2'd0;
      fs_q     <= '0;
      fe_q     <= '0;
      ss_q     <= '0;
      se_q     <= '0;
      snew_q   <= 1'b0;
      enew_q   <= 1'b0;
      case (req_q)
        REQ_INSERT: begin
          if (ovf) begin
            status_q <= STAT_OVERFILL;
          end else begin
            snew_q <= in_a && upd_a.is_new;
            enew_q <= in_b && upd_b.is_new;
          end
        end
        REQ_POP_SMALL: begin
          if (empty_q) begin
            status_q <= STAT_NONE;
          end else begin
            count_q <= 2'd1;
            fs_q    <= s_q;
            fe_q    <= e_q;
          end
        end
        REQ_POP_POINT: begin
          if (!in_a || !occ_a) begin
            status_q <= STAT_NONE;
          end else begin
            count_q <= ent_a_q.v1 ? 2'd2 : 2'd1;
            fs_q    <= ent_a_q.s0;
            fe_q    <= ent_a_q.e0;
            if (ent_a_q.v1) begin
              ss_q <= ent_a_q.s1;
              se_q <= ent_a_q.e1;
            end
          end
        end
        default: begin
          if (!(in_a && upd_a.found) && !(in_b && upd_b.found)) status_q <= STAT_NONE;
        end
      endcase
    end
  end

  assign status_o       = status_q;
  assign edge_count_o   = count_q;
  assign first_start_o  = fs_q;
  assign first_end_o    = fe_q;
  assign second_start_o = ss_q;
  assign second_end_o   = se_q;
  assign start_is_new_o = snew_q;
  assign end_is_new_o   = enew_q;

endmodule

`default_nettype wire

// ===== rtl/core/degree_two_edge_table.sv =====
// top level of the edge table
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | req_type, edge_start, edge_end, query_point
//   rsp_o   | out | valid / ready | status, edge_count, edge fields, new flags
//
// insert and remove read a, read b, capture b, write a and write b, then load the result;
// pop point skips write b. two reads and up to two writes on the single-port entry memory
// set these steps. pop smallest reads and checks the occupancy rows in turn (32 points a
// row, 4 if NUM_POINTS < 32), then reads the found point and runs the remove steps; an
// empty table loads its result after the last row. after reset a clearing pass zeroes the
// rows and takes no request meanwhile. one request is in flight at a time; a new one is
// taken while the previous result still waits, and a waiting result holds the final load.
`default_nettype none

module degree_two_edge_table
  import dte_pkg::*;
#(
  parameter int unsigned NUM_POINTS = NumPointsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dte_req_if.sink      req_i,
  dte_rsp_if.source    rsp_o
);

  cmd_t cmd;
  sts_t sts;

  dte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dte_datapath #(
    .NUM_POINTS (NUM_POINTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_i.req_type),
    .edge_start_i   (req_i.edge_start),
    .edge_end_i     (req_i.edge_end),
    .query_point_i  (req_i.query_point),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (rsp_o.status),
    .edge_count_o   (rsp_o.edge_count),
    .first_start_o  (rsp_o.first_start),
    .first_end_o    (rsp_o.first_end),
    .second_start_o (rsp_o.second_start),
    .second_end_o   (rsp_o.second_end),
    .start_is_new_o (rsp_o.start_is_new),
    .end_is_new_o   (rsp_o.end_is_new)
  );

endmodule

`default_nettype wire

// ===== sim/degree_two_edge_table_tb.sv =====
// testbench for the edge table: random and directed requests checked by a scoreboard
`default_nettype none

module degree_two_edge_table_tb;
  import dte_pkg::*;

  localparam int unsigned NPTS = NumPointsDef;

  typedef struct packed {
    logic [1:0]     status;
    logic [1:0]     edge_count;
    logic [IdW-1:0] first_start;
    logic [IdW-1:0] first_end;
    logic [IdW-1:0] second_start;
    logic [IdW-1:0] second_end;
    logic           start_is_new;
    logic           end_is_new;
  } edge_rsp_t;

  // shadow edge table and queue of predicted responses
  class edge_table_sb;
    bit             slot_v [NPTS][2];
    bit [IdW-1:0]   slot_s [NPTS][2];
    bit [IdW-1:0]   slot_e [NPTS][2];
    bit             occ [NPTS];
    edge_rsp_t      pending_rsp[$];
    int             errors;

    function void clear_entry(int p);
      for (int k = 0; k < 2; k++) begin
        slot_v[p][k] = 0; slot_s[p][k] = '0; slot_e[p][k] = '0;
      end
      occ[p] = 0;
    endfunction

    function bit has_edge(int p, bit [IdW-1:0] s, bit [IdW-1:0] e);
      bit hit;
      hit = 0;
      if (occ[p])
        for (int k = 0; k < 2; k++)
          if (slot_v[p][k] && slot_s[p][k] == s && slot_e[p][k] == e) hit = 1;
      return hit;
    endfunction

    function bit full_without(int p, bit [IdW-1:0] s, bit [IdW-1:0] e);
      if (p >= NPTS || !occ[p] || has_edge(p, s, e)) return 0;
      return slot_v[p][1];
    endfunction

    function bit add_edge(int p, bit [IdW-1:0] s, bit [IdW-1:0] e);
      if (p >= NPTS) return 0;
      if (!occ[p]) begin
        clear_entry(p);
        slot_v[p][0] = 1; slot_s[p][0] = s; slot_e[p][0] = e; occ[p] = 1;
        return 1;
      end
      if (!has_edge(p, s, e)) begin
        slot_v[p][1] = 1; slot_s[p][1] = s; slot_e[p][1] = e;
      end
      return 0;
    endfunction

    function bit drop_edge(int p, bit [IdW-1:0] s, bit [IdW-1:0] e);
      if (p >= NPTS || !occ[p]) return 0;
      if (slot_v[p][0] && slot_s[p][0] == s && slot_e[p][0] == e) begin
        slot_v[p][0] = slot_v[p][1]; slot_s[p][0] = slot_s[p][1]; slot_e[p][0] = slot_e[p][1];
        slot_v[p][1] = 0; slot_s[p][1] = '0; slot_e[p][1] = '0;
        if (!slot_v[p][0]) clear_entry(p);
        return 1;
      end
      if (slot_v[p][1] && slot_s[p][1] == s && slot_e[p][1] == e) begin
        slot_v[p][1] = 0; slot_s[p][1] = '0; slot_e[p][1] = '0;
        return 1;
      end
      return 0;
    endfunction

    function void note_request(req_e req, bit [IdW-1:0] s, bit [IdW-1:0] e,
                               bit [IdW-1:0] q);
      edge_rsp_t r;
      int p, n;
      bit a, b;
      bit [IdW-1:0] ps, pe;
      r = '0;
      case (req)
        REQ_INSERT: begin
          if (full_without(s, s, e) || (e != s && full_without(e, s, e))) begin
            r.status = STAT_OVERFILL;
          end else begin
            r.start_is_new = add_edge(s, s, e);
            r.end_is_new   = (e != s) ? add_edge(e, s, e) : 1'b0;
          end
        end
        REQ_POP_SMALL: begin
          p = -1;
          for (int i = 0; i < NPTS; i++)
            if (occ[i] && p < 0) p = i;
          if (p < 0) begin
            r.status = STAT_NONE;
          end else begin
            ps = slot_s[p][0]; pe = slot_e[p][0];
            void'(drop_edge(ps, ps, pe));
            if (pe != ps) void'(drop_edge(pe, ps, pe));
            r.edge_count = 2'd1; r.first_start = ps; r.first_end = pe;
          end
        end
        REQ_POP_POINT: begin
          if (q >= NPTS || !occ[q]) begin
            r.status = STAT_NONE;
          end else begin
            n = 0;
            for (int k = 0; k < 2; k++)
              if (slot_v[q][k]) begin
                if (n == 0) begin
                  r.first_start = slot_s[q][k]; r.first_end = slot_e[q][k];
                end else begin
                  r.second_start = slot_s[q][k]; r.second_end = slot_e[q][k];
                end
                n++;
              end
            r.edge_count = 2'(n);
            clear_entry(q);
          end
        end
        default: begin
          a = drop_edge(s, s, e);
          b = (e != s) ? drop_edge(e, s, e) : 1'b0;
          if (!a && !b) r.status = STAT_NONE;
        end
      endcase
      pending_rsp = {pending_rsp, r};
    endfunction

    function void check_response(edge_rsp_t got);
      edge_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
        $display("%0t: response mismatch expected %h actual %h", $time, want, got);
        $display("  status %0d/%0d count %0d/%0d e1 %0d,%0d/%0d,%0d e2 %0d,%0d/%0d,%0d new %b%b/%b%b",
                 want.status, got.status, want.edge_count, got.edge_count,
                 want.first_start, want.first_end, got.first_start, got.first_end,
                 want.second_start, want.second_end, got.second_start, got.second_end,
                 want.start_is_new, want.end_is_new, got.start_is_new, got.end_is_new);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  dte_req_if req_if ();
  dte_rsp_if rsp_if ();

  degree_two_edge_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  edge_table_sb sb;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // acceptance monitor: predict on request, check on response
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_e'(req_if.req_type), req_if.edge_start, req_if.edge_end,
                        req_if.query_point);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response({rsp_if.status, rsp_if.edge_count, rsp_if.first_start,
                           rsp_if.first_end, rsp_if.second_start, rsp_if.second_end,
                           rsp_if.start_is_new, rsp_if.end_is_new});
    end
  end

  // response sink with random stalls
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(req_e req, int s, int e, int q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= req;
    req_if.edge_start  <= s[IdW-1:0];
    req_if.edge_end    <= e[IdW-1:0];
    req_if.query_point <= q[IdW-1:0];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  // mostly small ids so edges collide and fill points
  function automatic int pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(15);
    if (r < 90) return $urandom_range(1023);
    return 1023 - $urandom_range(3);
  endfunction

  task automatic random_phase(int count);
    int r, s, e;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      s = pick_id();
      e = ($urandom_range(9) == 0) ? s : pick_id();
      if (r < 45)      send_request(REQ_INSERT, s, e, $urandom);
      else if (r < 60) send_request(REQ_POP_SMALL, $urandom, $urandom, $urandom);
      else if (r < 75) send_request(REQ_POP_POINT, $urandom, $urandom, pick_id());
      else             send_request(REQ_REMOVE, s, e, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.errors = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.edge_start = '0;
    req_if.edge_end = '0;
    req_if.query_point = '0;
    rsp_if.ready = 1'b0;
    for (int p = 0; p < NPTS; p++) sb.clear_entry(p);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, duplicates, self loop, overfill, removes
    send_request(REQ_POP_SMALL, 0, 0, 0);
    send_request(REQ_POP_POINT, 0, 0, 1023);
    send_request(REQ_REMOVE, 5, 6, 0);
    send_request(REQ_INSERT, 1023, 0, 0);
    send_request(REQ_INSERT, 1023, 0, 0);
    send_request(REQ_INSERT, 0, 1023, 0);
    send_request(REQ_INSERT, 0, 512, 0);
    send_request(REQ_INSERT, 7, 7, 0);
    send_request(REQ_INSERT, 7, 7, 0);
    send_request(REQ_INSERT, 7, 8, 0);
    send_request(REQ_INSERT, 7, 9, 0);
    send_request(REQ_INSERT, 341, 682, 0);
    send_request(REQ_REMOVE, 682, 341, 0);
    send_request(REQ_REMOVE, 341, 682, 0);
    send_request(REQ_POP_POINT, 0, 0, 0);
    send_request(REQ_POP_POINT, 0, 0, 1023);
    send_request(REQ_REMOVE, 7, 7, 0);
    send_request(REQ_POP_SMALL, 0, 0, 0);
    send_request(REQ_POP_SMALL, 0, 0, 0);
    send_request(REQ_POP_SMALL, 0, 0, 0);
    send_request(REQ_POP_POINT, 0, 0, 512);
    drain();

    random_phase(500);
    drain();
    send_idle_pct = 68;
    random_phase(450);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    random_phase(450);
    drain();
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    random_phase(550);
    drain();

    repeat (300) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
